### design/object_slot_table_assert.svh
// ----------------------------------------------------------------------------
// object_slot_table_assert.svh
// Assertion macros for the slot table checks.
// ----------------------------------------------------------------------------
`ifndef OBJECT_SLOT_TABLE_ASSERT_SVH
`define OBJECT_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg
// Shared constants, operation codes and control types of the slot table.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int SLOTS  = 256;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int OP_W   = 3;
  localparam int ID_W   = 16;
  localparam int IDX_W  = 9;
  localparam int SLOT_W = 8;
  localparam int MARK_W = 9;

  localparam logic [ID_W-1:0] ID_LOW_MASK = 16'h07FF;

  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND_EQ  = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_RNG = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_MSK = 3'd4;
  localparam logic [OP_W-1:0] OP_RECOMP   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

### design/ost_ctrl.sv
// ----------------------------------------------------------------------------
// ost_ctrl
// Request sequencer: accepts a request, runs a scan or a single-cycle
// action in the datapath, and strobes the result.
// ----------------------------------------------------------------------------
module ost_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ost_pkg::OP_W-1:0]   in_operation,
  input  ost_pkg::sts_t              sts,
  output ost_pkg::cmd_t              cmd,
  output logic                       busy,
  output logic                       out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       is_scan;

  always_comb begin
    case (in_operation)
      ost_pkg::OP_ALLOC,
      ost_pkg::OP_FIND_EQ,
      ost_pkg::OP_FIND_RNG,
      ost_pkg::OP_FIND_MSK,
      ost_pkg::OP_RECOMP: is_scan = 1'b1;
      default:            is_scan = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = is_scan ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/ost_datapath.sv
// ----------------------------------------------------------------------------
// ost_datapath
// Slot memory with per-slot valid bits, scan pointer, match logic,
// high-water mark and result registers.
// ----------------------------------------------------------------------------
module ost_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ost_pkg::cmd_t                      cmd,
  output ost_pkg::sts_t                      sts,
  input  logic [ost_pkg::OP_W-1:0]           in_operation,
  input  logic [ost_pkg::ID_W-1:0]           in_id_value,
  input  logic [ost_pkg::ID_W-1:0]           in_id_upper,
  input  logic signed [ost_pkg::IDX_W-1:0]   in_slot_index,
  output logic                               out_found,
  output logic [ost_pkg::SLOT_W-1:0]         out_slot_out,
  output logic [ost_pkg::ID_W-1:0]           out_id_out,
  output logic [ost_pkg::MARK_W-1:0]         out_mark_out
);

  logic [ost_pkg::ID_W-1:0]   mem [ost_pkg::SLOTS];
  logic [ost_pkg::SLOTS-1:0]  vld_r;

  logic [ost_pkg::OP_W-1:0]   op_r;
  logic [ost_pkg::ID_W-1:0]   val_r;
  logic [ost_pkg::ID_W-1:0]   upper_r;
  logic [ost_pkg::IDX_W-1:0]  idx_r;
  logic [ost_pkg::CNT_W-1:0]  addr_r;
  logic [ost_pkg::CNT_W-1:0]  lim_r;
  logic [ost_pkg::CNT_W-1:0]  last_r;
  logic [ost_pkg::MARK_W-1:0] mark_r;
  logic [ost_pkg::ADDR_W-1:0] rd_idx_r;
  logic [ost_pkg::ID_W-1:0]   rd_data_r;
  logic                       rd_vld_r;
  logic                       pend_r;
  logic                       found_r;
  logic [ost_pkg::SLOT_W-1:0] slot_r;
  logic [ost_pkg::ID_W-1:0]   id_r;

  logic [ost_pkg::CNT_W-1:0]  start_addr;
  logic [ost_pkg::CNT_W-1:0]  start_lim;
  logic [ost_pkg::ID_W-1:0]   entry;
  logic [ost_pkg::ID_W-1:0]   entry_low;
  logic                       match;
  logic                       hit;
  logic                       scan_end;
  logic                       finish;
  logic                       rd_en;
  logic                       wr_en;
  logic                       rel_en;
  logic                       clr_en;
  logic [ost_pkg::CNT_W-1:0]  hit_next;
  logic [ost_pkg::CNT_W-1:0]  last_nxt;
  logic [ost_pkg::MARK_W-1:0] mark_nxt;

  always_comb begin
    start_addr = '0;
    start_lim  = '0;
    case (in_operation)
      ost_pkg::OP_ALLOC,
      ost_pkg::OP_RECOMP: begin
        start_lim = ost_pkg::CNT_W'(ost_pkg::SLOTS);
      end
      ost_pkg::OP_FIND_EQ,
      ost_pkg::OP_FIND_RNG,
      ost_pkg::OP_FIND_MSK: begin
        start_addr = in_slot_index[ost_pkg::IDX_W-1] ? '0 :
          ost_pkg::CNT_W'(in_slot_index[ost_pkg::IDX_W-2:0]) + ost_pkg::CNT_W'(1);
        start_lim  = (mark_r > ost_pkg::MARK_W'(ost_pkg::SLOTS)) ?
          ost_pkg::CNT_W'(ost_pkg::SLOTS) : ost_pkg::CNT_W'(mark_r);
      end
      default: begin
        start_addr = '0;
        start_lim  = '0;
      end
    endcase
  end

  assign entry     = rd_vld_r ? rd_data_r : '0;
  assign entry_low = entry & ost_pkg::ID_LOW_MASK;

  always_comb begin
    case (op_r)
      ost_pkg::OP_ALLOC:    match = (entry == '0);
      ost_pkg::OP_FIND_EQ:  match = (entry_low == (val_r & ost_pkg::ID_LOW_MASK));
      ost_pkg::OP_FIND_RNG: match = (entry_low >= (val_r & ost_pkg::ID_LOW_MASK)) &&
                                    (entry_low <= (upper_r & ost_pkg::ID_LOW_MASK));
      ost_pkg::OP_FIND_MSK: match = ((entry & val_r) != '0);
      default:              match = 1'b0;
    endcase
  end

  assign hit      = pend_r && match;
  assign scan_end = (addr_r >= lim_r) && !hit;
  assign sts.done = hit || scan_end;
  assign finish   = cmd.exec || (cmd.scan && sts.done);
  assign rd_en    = cmd.scan && (addr_r < lim_r);
  assign hit_next = ost_pkg::CNT_W'(rd_idx_r) + ost_pkg::CNT_W'(1);
  assign last_nxt = (pend_r && (entry != '0)) ? hit_next : last_r;

  assign wr_en  = finish && (op_r == ost_pkg::OP_ALLOC) && hit;
  assign rel_en = cmd.exec && (op_r == ost_pkg::OP_RELEASE) && !idx_r[ost_pkg::IDX_W-1] &&
                  (int'(idx_r) < ost_pkg::SLOTS);
  assign clr_en = cmd.exec && (op_r == ost_pkg::OP_CLEAR);

  always_comb begin
    mark_nxt = mark_r;
    if (finish) begin
      if (wr_en && (ost_pkg::MARK_W'(hit_next) > mark_r)) begin
        mark_nxt = ost_pkg::MARK_W'(hit_next);
      end else if (op_r == ost_pkg::OP_RECOMP) begin
        mark_nxt = ost_pkg::MARK_W'(last_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_idx_r] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r[ost_pkg::ADDR_W-1:0]];
      rd_vld_r  <= vld_r[addr_r[ost_pkg::ADDR_W-1:0]];
      rd_idx_r  <= addr_r[ost_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mark_r <= '0;
      pend_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
      if (clr_en) begin
        vld_r <= '0;
      end else begin
        if (wr_en) begin
          vld_r[rd_idx_r] <= 1'b1;
        end
        if (rel_en) begin
          vld_r[idx_r[ost_pkg::ADDR_W-1:0]] <= 1'b0;
        end
      end
      if (cmd.load) begin
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      val_r   <= in_id_value;
      upper_r <= in_id_upper;
      idx_r   <= in_slot_index;
      addr_r  <= start_addr;
      lim_r   <= start_lim;
      last_r  <= '0;
    end else if (cmd.scan) begin
      last_r <= last_nxt;
      if (rd_en) begin
        addr_r <= addr_r + ost_pkg::CNT_W'(1);
      end
    end
    if (finish) begin
      found_r <= hit;
      slot_r  <= hit ? ost_pkg::SLOT_W'(rd_idx_r) : '0;
      id_r    <= !hit ? '0 : ((op_r == ost_pkg::OP_ALLOC) ? val_r : entry);
    end
  end

  assign out_found    = found_r;
  assign out_slot_out = slot_r;
  assign out_id_out   = id_r;
  assign out_mark_out = mark_r;

endmodule

### design/object_slot_table.sv
// ----------------------------------------------------------------------------
// object_slot_table
// First-fit slot allocator with ID searches over a 256-slot table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate, the three
// searches and recompute walk the slot memory one slot per cycle through a
// single registered read port; a search stops at its first hit and at the
// high-water mark. Release, clear-all and unused codes skip the scan and
// finish in the exec state. Each result is presented for exactly one cycle
// with out_valid, in the first cycle with busy low, and cannot be held off:
// the receiver must take it then. Slot contents come up free after reset
// with no clearing pass.
// ----------------------------------------------------------------------------
module object_slot_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ost_pkg::OP_W-1:0]           in_operation,
  input  logic [ost_pkg::ID_W-1:0]           in_id_value,
  input  logic [ost_pkg::ID_W-1:0]           in_id_upper,
  input  logic signed [ost_pkg::IDX_W-1:0]   in_slot_index,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [ost_pkg::SLOT_W-1:0]         out_slot_out,
  output logic [ost_pkg::ID_W-1:0]           out_id_out,
  output logic [ost_pkg::MARK_W-1:0]         out_mark_out
);

`include "object_slot_table_assert.svh"

  ost_pkg::cmd_t cmd;
  ost_pkg::sts_t sts;

  ost_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  ost_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_operation  (in_operation),
    .in_id_value   (in_id_value),
    .in_id_upper   (in_id_upper),
    .in_slot_index (in_slot_index),
    .out_found     (out_found),
    .out_slot_out  (out_slot_out),
    .out_id_out    (out_id_out),
    .out_mark_out  (out_mark_out)
  );

  `OST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `OST_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `OST_ASSERT_NOW(a_miss_zero, out_valid && !out_found, (out_slot_out == '0) && (out_id_out == '0), "miss with nonzero slot or id")
  `OST_ASSERT_NOW(a_mark_bound, out_valid, out_mark_out <= ost_pkg::MARK_W'(ost_pkg::SLOTS), "mark above slot count")

endmodule

### test/tb_object_slot_table.sv
// ----------------------------------------------------------------------------
// tb_object_slot_table
// Self-checking testbench for the first-fit slot allocator.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the slot table and high-water mark. It
// predicts each result at the moment a request is taken and compares every
// strobed result with the oldest prediction. The stimulus starts with a short
// directed sequence of corner cases. A burst of allocations then fills the
// table to full, and random traffic is steered by the predicted table
// contents. The random traffic runs under several sender gap rates.
// ----------------------------------------------------------------------------
module tb_object_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ost_pkg::OP_W-1:0] OP_UNUSED   = 3'd7;
  localparam int                       CYCLE_LIMIT = 2_000_000;
  localparam int                       RAND_PER_PH = 200;
  localparam int                       MAX_REPORTS = 10;

  typedef struct packed {
    logic [ost_pkg::OP_W-1:0]  op;
    logic [ost_pkg::ID_W-1:0]  id_value;
    logic [ost_pkg::ID_W-1:0]  id_upper;
    logic [ost_pkg::IDX_W-1:0] slot_index;
  } slot_req_t;

  typedef struct packed {
    logic                       found;
    logic [ost_pkg::SLOT_W-1:0] slot;
    logic [ost_pkg::ID_W-1:0]   id;
    logic [ost_pkg::MARK_W-1:0] mark;
  } slot_resp_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [ost_pkg::OP_W-1:0]          in_operation = '0;
  logic [ost_pkg::ID_W-1:0]          in_id_value = '0;
  logic [ost_pkg::ID_W-1:0]          in_id_upper = '0;
  logic signed [ost_pkg::IDX_W-1:0]  in_slot_index = '0;
  logic                              busy;
  logic                              out_valid;
  logic                              out_found;
  logic [ost_pkg::SLOT_W-1:0]        out_slot_out;
  logic [ost_pkg::ID_W-1:0]          out_id_out;
  logic [ost_pkg::MARK_W-1:0]        out_mark_out;

  slot_req_t  pending_requests[$];
  slot_resp_t expected_results[$];
  slot_req_t  next_req;
  slot_resp_t got_resp;
  slot_resp_t want_resp;

  logic [ost_pkg::ID_W-1:0] table_ids [ost_pkg::SLOTS];
  int                       hwm = 0;

  bit  took = 1'b0;
  int  gap_pct = 0;
  int  pushed_count = 0;
  int  accepted_count = 0;
  int  checked_count = 0;
  int  mismatch_count = 0;
  int  search_hits = 0;
  int  full_count = 0;
  int  cycle_count = 0;

  object_slot_table i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_id_value  (in_id_value),
    .in_id_upper  (in_id_upper),
    .in_slot_index(in_slot_index),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_slot_out (out_slot_out),
    .out_id_out   (out_id_out),
    .out_mark_out (out_mark_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic slot_resp_t apply_slot_request(slot_req_t r);
    slot_resp_t               res;
    int                       first;
    int                       lim;
    bit                       hit;
    logic [ost_pkg::ID_W-1:0] low;
    res = '0;
    hit = 1'b0;
    case (r.op)
      ost_pkg::OP_ALLOC: begin
        for (int i = 0; i < ost_pkg::SLOTS && !hit; i++) begin
          if (table_ids[i] == '0) begin
            table_ids[i] = r.id_value;
            if (i >= hwm) hwm = i + 1;
            hit = 1'b1;
            res.found = 1'b1;
            res.slot = ost_pkg::SLOT_W'(i);
            res.id = r.id_value;
          end
        end
        if (!hit) full_count++;
      end
      ost_pkg::OP_RELEASE: begin
        if (!r.slot_index[ost_pkg::IDX_W-1])
          table_ids[r.slot_index[ost_pkg::SLOT_W-1:0]] = '0;
      end
      ost_pkg::OP_FIND_EQ, ost_pkg::OP_FIND_RNG, ost_pkg::OP_FIND_MSK: begin
        first = r.slot_index[ost_pkg::IDX_W-1] ? 0 : int'(r.slot_index) + 1;
        lim = (hwm < ost_pkg::SLOTS) ? hwm : ost_pkg::SLOTS;
        for (int i = first; i < lim && !hit; i++) begin
          low = table_ids[i] & ost_pkg::ID_LOW_MASK;
          case (r.op)
            ost_pkg::OP_FIND_EQ:  hit = (low == (r.id_value & ost_pkg::ID_LOW_MASK));
            ost_pkg::OP_FIND_RNG: hit = (low >= (r.id_value & ost_pkg::ID_LOW_MASK)) &&
                                        (low <= (r.id_upper & ost_pkg::ID_LOW_MASK));
            default:              hit = ((table_ids[i] & r.id_value) != '0);
          endcase
          if (hit) begin
            res.found = 1'b1;
            res.slot = ost_pkg::SLOT_W'(i);
            res.id = table_ids[i];
          end
        end
        if (hit) search_hits++;
      end
      ost_pkg::OP_RECOMP: begin
        hwm = ost_pkg::SLOTS;
        while (hwm > 0 && table_ids[hwm-1] == '0) hwm--;
      end
      ost_pkg::OP_CLEAR: begin
        for (int i = 0; i < ost_pkg::SLOTS; i++) table_ids[i] = '0;
      end
      default: ;
    endcase
    res.mark = ost_pkg::MARK_W'(hwm);
    return res;
  endfunction

  function automatic logic [ost_pkg::ID_W-1:0] random_id();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return ost_pkg::ID_W'($urandom_range(65535));
      default: return {5'($urandom_range(31)), 11'($urandom_range(15))};
    endcase
  endfunction

  function automatic int pick_slot();
    return (hwm == 0) ? 0 :
      $urandom_range((hwm < ost_pkg::SLOTS ? hwm : ost_pkg::SLOTS) - 1);
  endfunction

  function automatic logic [ost_pkg::IDX_W-1:0] search_start();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return '1;
    if (pick < 9) return ost_pkg::IDX_W'(pick_slot());
    return ost_pkg::IDX_W'($urandom_range(255));
  endfunction

  function automatic slot_req_t random_request();
    slot_req_t                r;
    int                       pick;
    logic [ost_pkg::ID_W-1:0] base;
    logic [ost_pkg::ID_W-1:0] tmp;
    pick = $urandom_range(99);
    r.id_value = random_id();
    r.id_upper = ost_pkg::ID_W'($urandom_range(65535));
    r.slot_index = search_start();
    base = table_ids[pick_slot()];
    if (pick < 35) begin
      r.op = ost_pkg::OP_ALLOC;
    end else if (pick < 55) begin
      r.op = ost_pkg::OP_RELEASE;
      case ($urandom_range(9))
        0:       r.slot_index = '1;
        1:       r.slot_index = ost_pkg::IDX_W'($urandom_range(255));
        default: r.slot_index = ost_pkg::IDX_W'(pick_slot());
      endcase
    end else if (pick < 67) begin
      r.op = ost_pkg::OP_FIND_EQ;
      if ($urandom_range(9) < 7) r.id_value = {5'($urandom_range(31)), base[10:0]};
    end else if (pick < 77) begin
      r.op = ost_pkg::OP_FIND_RNG;
      if ($urandom_range(9) < 8) begin
        r.id_value = {5'($urandom_range(31)), base[10:0] - 11'($urandom_range(3))};
        r.id_upper = {5'($urandom_range(31)), base[10:0] + 11'($urandom_range(40))};
        if ($urandom_range(9) == 0) begin
          tmp = r.id_value;
          r.id_value = r.id_upper;
          r.id_upper = tmp;
        end
      end
    end else if (pick < 87) begin
      r.op = ost_pkg::OP_FIND_MSK;
      if ($urandom_range(1) == 0) r.id_value = ost_pkg::ID_W'(1) << $urandom_range(15);
    end else if (pick < 97) begin
      r.op = ost_pkg::OP_RECOMP;
    end else begin
      r.op = ost_pkg::OP_CLEAR;
    end
    return r;
  endfunction

  task automatic push_op(input logic [ost_pkg::OP_W-1:0] op,
                         input logic [ost_pkg::ID_W-1:0] val,
                         input logic [ost_pkg::ID_W-1:0] upper,
                         input logic [ost_pkg::IDX_W-1:0] idx);
    pending_requests.push_back('{op: op, id_value: val, id_upper: upper, slot_index: idx});
    pushed_count++;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || accepted_count != pushed_count ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  // drive requests on the falling edge; hold until taken
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_req = pending_requests.pop_front();
        start <= 1'b1;
        in_operation <= next_req.op;
        in_id_value <= next_req.id_value;
        in_id_upper <= next_req.id_upper;
        in_slot_index <= next_req.slot_index;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        got_resp = '{found: out_found, slot: out_slot_out, id: out_id_out,
                     mark: out_mark_out};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result %p", $realtime, got_resp);
        end else begin
          want_resp = expected_results.pop_front();
          checked_count++;
          if (got_resp !== want_resp) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: result %0d mismatch: expected %p, got %p",
                       $realtime, checked_count, want_resp, got_resp);
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_slot_request('{op: in_operation,
          id_value: in_id_value, id_upper: in_id_upper, slot_index: in_slot_index}));
        accepted_count++;
      end
      took <= start && !busy;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int gaps [3];
    gaps = '{0, 52, 32};
    for (int i = 0; i < ost_pkg::SLOTS; i++) table_ids[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    push_op(ost_pkg::OP_FIND_EQ,  16'h0000, 16'h0000, 9'h1FF);
    push_op(ost_pkg::OP_RECOMP,   16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_ALLOC,    16'hFFFF, 16'hFFFF, 9'h0FF);
    push_op(ost_pkg::OP_ALLOC,    16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_ALLOC,    16'h0801, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_ALLOC,    16'h1234, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_FIND_EQ,  16'hF801, 16'h0000, 9'h1FF);
    push_op(ost_pkg::OP_RELEASE,  16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_FIND_EQ,  16'h0000, 16'h0000, 9'h1FF);
    push_op(ost_pkg::OP_FIND_RNG, 16'h0000, 16'hF7FF, 9'h000);
    push_op(ost_pkg::OP_FIND_RNG, 16'h0300, 16'h0200, 9'h1FF);
    push_op(ost_pkg::OP_FIND_MSK, 16'h1000, 16'h0000, 9'h1FF);
    push_op(ost_pkg::OP_FIND_MSK, 16'hFFFF, 16'h0000, 9'h002);
    push_op(ost_pkg::OP_FIND_EQ,  16'h0234, 16'h0000, ost_pkg::IDX_W'(-5));
    push_op(ost_pkg::OP_FIND_EQ,  16'h0801, 16'h0000, 9'h0FF);
    push_op(ost_pkg::OP_FIND_EQ,  16'h0801, 16'h0000, 9'h100);
    push_op(ost_pkg::OP_RELEASE,  16'hFFFF, 16'hFFFF, 9'h1FF);
    push_op(ost_pkg::OP_RELEASE,  16'h0000, 16'h0000, 9'h0FF);
    push_op(OP_UNUSED,            16'hFFFF, 16'hFFFF, 9'h1FF);
    push_op(ost_pkg::OP_RELEASE,  16'h0000, 16'h0000, 9'h002);
    push_op(ost_pkg::OP_RECOMP,   16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_CLEAR,    16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_RECOMP,   16'h0000, 16'h0000, 9'h000);
    push_op(ost_pkg::OP_FIND_RNG, 16'h0000, 16'hFFFF, 9'h1FF);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = gaps[ph];
      if (ph == 0) begin
        push_op(ost_pkg::OP_CLEAR, 16'h0000, 16'h0000, 9'h000);
        for (int n = 0; n < ost_pkg::SLOTS + 2; n++)
          push_op(ost_pkg::OP_ALLOC, ost_pkg::ID_W'($urandom_range(1, 65535)),
                  16'h0000, 9'h000);
      end
      for (int n = 0; n < RAND_PER_PH; n++) begin
        while (pending_requests.size() >= 2) @(posedge clk);
        pending_requests.push_back(random_request());
        pushed_count++;
      end
      drain();
    end

    repeat (ost_pkg::SLOTS + 8) @(posedge clk);
    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
    $display("checked %0d results from %0d requests: %0d search hits, %0d full-table allocs",
             checked_count, accepted_count, search_hits, full_count);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
